FILE: src/ooke_pkg.sv
// Package for the OOK remote frame encoder: types, constants and register indexes.
`timescale 1ns / 1ps
package ooke_pkg;

    // Key bits sent per frame, most significant first.
    localparam int KEY_BITS = 32;

    localparam int UNIT_W  = 16;
    localparam int KEY_W   = 32;
    localparam int POS_W   = 6;
    localparam int UCNT_W  = 7;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 32;

    localparam logic [UNIT_W-1:0] UNIT_TICKS_RST = 16'd270;
    localparam logic [KEY_W-1:0]  KEY_ONE_RST    = 32'hC0C0_C0C0;
    localparam logic [KEY_W-1:0]  KEY_TWO_RST    = 32'hA0A0_A0A0;
    localparam logic [KEY_W-1:0]  KEY_THREE_RST  = 32'hB0B0_B0B0;

    // Segment lengths in units
    localparam logic [UCNT_W-1:0] SYNC_H_UNITS = 7'd4;
    localparam logic [UCNT_W-1:0] SYNC_L_UNITS = 7'd124;
    localparam logic [UCNT_W-1:0] LONG_UNITS   = 7'd3;
    localparam logic [UCNT_W-1:0] SHORT_UNITS  = 7'd1;

    localparam logic [POS_W-1:0] START_POS = POS_W'(KEY_BITS - 1);

    typedef enum logic [CFG_AW-1:0] {
        REG_UNIT_TICKS = 2'd0,
        REG_KEY_ONE    = 2'd1,
        REG_KEY_TWO    = 2'd2,
        REG_KEY_THREE  = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        BTN_NONE  = 2'd0,
        BTN_ONE   = 2'd1,
        BTN_TWO   = 2'd2,
        BTN_THREE = 2'd3
    } button_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SYNC_H = 3'd1,
        PH_SYNC_L = 3'd2,
        PH_BIT_H  = 3'd3,
        PH_BIT_L  = 3'd4
    } phase_t;

    typedef struct packed {
        logic [UNIT_W-1:0] unit_ticks;
        logic [KEY_W-1:0]  key_one;
        logic [KEY_W-1:0]  key_two;
        logic [KEY_W-1:0]  key_three;
    } cfg_t;

    typedef struct packed {
        logic frame_done;
        logic busy_res;
        logic line_level;
    } res_t;

endpackage

FILE: src/ooke_cfg.sv
// Configuration register file: tick unit and the three key codes.
`timescale 1ns / 1ps
module ooke_cfg
    import ooke_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_data,
    output cfg_t              cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_ticks <= UNIT_TICKS_RST;
            cfg_reg.key_one    <= KEY_ONE_RST;
            cfg_reg.key_two    <= KEY_TWO_RST;
            cfg_reg.key_three  <= KEY_THREE_RST;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_UNIT_TICKS: cfg_reg.unit_ticks <= cfg_data[UNIT_W-1:0];
                REG_KEY_ONE:    cfg_reg.key_one    <= cfg_data[KEY_W-1:0];
                REG_KEY_TWO:    cfg_reg.key_two    <= cfg_data[KEY_W-1:0];
                REG_KEY_THREE:  cfg_reg.key_three  <= cfg_data[KEY_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/ooke_seq.sv
// Frame sequencer: phase, bit, unit and tick counters plus the pending press slot.
`timescale 1ns / 1ps
module ooke_seq
    import ooke_pkg::*;
#(
    parameter int KEY_LEN = KEY_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       req_take,
    input  logic       action,
    input  logic [1:0] button,
    output res_t       res
);

    localparam logic [POS_W-1:0] FIRST_POS = POS_W'(KEY_LEN - 1);

    phase_t              phase_reg, phase_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [UCNT_W-1:0]   ucnt_reg, ucnt_next;
    logic [UNIT_W-1:0]   tcnt_reg, tcnt_next;
    logic [KEY_W-1:0]    shift_reg, shift_next;
    button_t             pend_reg, pend_next;

    logic                busy_now;
    logic                cur_bit;
    logic [UNIT_W-1:0]   limit;
    logic [UNIT_W-1:0]   tcnt_inc;
    logic [UCNT_W-1:0]   ucnt_inc;
    logic [UCNT_W-1:0]   seg_units;
    logic                done;
    button_t             start_btn;
    logic                start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            ucnt_reg  <= '0;
            tcnt_reg  <= '0;
            shift_reg <= '0;
            pend_reg  <= BTN_NONE;
        end
        else if (req_take)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            ucnt_reg  <= ucnt_next;
            tcnt_reg  <= tcnt_next;
            shift_reg <= shift_next;
            pend_reg  <= pend_next;
        end
    end

    always_comb
    begin
        busy_now  = (phase_reg == PH_SYNC_H) || (phase_reg == PH_SYNC_L) ||
                    (phase_reg == PH_BIT_H)  || (phase_reg == PH_BIT_L);
        // positions above bit 31 send zero
        cur_bit   = (pos_reg[POS_W-1] == 1'b0) && shift_reg[pos_reg[POS_W-2:0]];
        limit     = (cfg.unit_ticks == '0) ? UNIT_W'(1) : cfg.unit_ticks;
        tcnt_inc  = tcnt_reg + UNIT_W'(1);
        ucnt_inc  = ucnt_reg + UCNT_W'(1);

        case (phase_reg)
            PH_SYNC_H: seg_units = SYNC_H_UNITS;
            PH_SYNC_L: seg_units = SYNC_L_UNITS;
            PH_BIT_H:  seg_units = cur_bit ? LONG_UNITS : SHORT_UNITS;
            default:   seg_units = cur_bit ? SHORT_UNITS : LONG_UNITS;
        endcase

        phase_next = busy_now ? phase_reg : PH_IDLE;
        pos_next   = pos_reg;
        ucnt_next  = ucnt_reg;
        tcnt_next  = tcnt_reg;
        shift_next = shift_reg;
        pend_next  = pend_reg;
        done       = 1'b0;
        start      = 1'b0;
        start_btn  = button_t'(button);

        if (action)
        begin
            if (button_t'(button) != BTN_NONE)
            begin
                if (busy_now)
                begin
                    pend_next = button_t'(button);
                end
                else
                begin
                    pend_next = BTN_NONE;
                    start     = 1'b1;
                end
            end
        end
        else if (busy_now)
        begin
            if ((tcnt_inc < limit) && (tcnt_inc != '0))
            begin
                tcnt_next = tcnt_inc;
            end
            else
            begin
                tcnt_next = '0;
                if (ucnt_inc < seg_units)
                begin
                    ucnt_next = ucnt_inc;
                end
                else
                begin
                    ucnt_next = '0;
                    case (phase_reg)
                        PH_SYNC_H: phase_next = PH_SYNC_L;
                        PH_SYNC_L: phase_next = PH_BIT_H;
                        PH_BIT_H:  phase_next = PH_BIT_L;
                        default:
                        begin
                            if (pos_reg == '0)
                            begin
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                            else
                            begin
                                pos_next   = pos_reg - POS_W'(1);
                                phase_next = PH_BIT_H;
                            end
                        end
                    endcase
                end
            end
        end
        else if (pend_reg != BTN_NONE)
        begin
            start     = 1'b1;
            start_btn = pend_reg;
            pend_next = BTN_NONE;
        end

        if (start)
        begin
            case (start_btn)
                BTN_ONE: shift_next = cfg.key_one;
                BTN_TWO: shift_next = cfg.key_two;
                default: shift_next = cfg.key_three;
            endcase
            phase_next = PH_SYNC_H;
            pos_next   = FIRST_POS;
            ucnt_next  = '0;
            tcnt_next  = '0;
        end

        res.line_level = (phase_next == PH_SYNC_H) || (phase_next == PH_BIT_H);
        res.busy_res   = (phase_next == PH_SYNC_H) || (phase_next == PH_SYNC_L) ||
                         (phase_next == PH_BIT_H)  || (phase_next == PH_BIT_L);
        res.frame_done = done;
    end

endmodule

FILE: src/ooke_obuf.sv
// Output register: holds one result until the downstream side takes it.
`timescale 1ns / 1ps
module ooke_obuf
    import ooke_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       res_load,
    input  res_t       res,
    output logic       load_ok,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic valid_reg;
    res_t res_reg;

    // a new result may enter when the slot is empty or drains this cycle
    assign load_ok = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_ok)
        begin
            valid_reg <= res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load && load_ok)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b0, res_reg.busy_res, res_reg.line_level};
    assign m_tlast  = res_reg.frame_done;

endmodule

FILE: src/ook_remote_frame_encoder.sv
// Top level of the OOK remote frame encoder.
//
//  channel   | signals                               | contents
//  ----------+---------------------------------------+------------------------------------
//  input     | s_tvalid s_tready s_tdata s_tuser     | tuser: action; tdata: button
//  output    | m_tvalid m_tready m_tdata m_tlast     | tdata: line_level, busy_res; tlast: frame_done
//  config    | cfg_we cfg_addr cfg_data              | 0 unit_ticks, 1..3 key codes
//
// One request per clock while the output is not stalled; its result is registered and appears on the next cycle.
// Throughput is one item per cycle, limited only by the single output register.
// rst_n (async) restores default config and idles the sequencer with nothing pending.
// A stalled output holds its result; input is taken again once it drains.
`timescale 1ns / 1ps
module ook_remote_frame_encoder
    import ooke_pkg::*;
#(
    parameter int KEY_LEN = KEY_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [1:0] button
    input  logic              s_tuser,   // [0] action
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [0] line_level, [1] busy_res
    output logic              m_tlast,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_data
);

    cfg_t cfg;
    res_t res;
    logic load_ok;
    logic req_take;

    assign s_tready = load_ok;
    assign req_take = s_tvalid && load_ok;

    ooke_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    ooke_seq #(
        .KEY_LEN  (KEY_LEN)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .req_take (req_take),
        .action   (s_tuser),
        .button   (s_tdata[1:0]),
        .res      (res)
    );

    ooke_obuf u_obuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_load (req_take),
        .res      (res),
        .load_ok  (load_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
